FILE: sv/cpfa_pkg.sv
// shared constants for the contiguous page-frame allocator
// field widths, operation codes and configuration register indexes
`default_nettype none

package cpfa_pkg;

    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 11;
    localparam int ENTRY_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE    = 1'd1;

    localparam logic [COUNT_W-1:0] FRAMES_IN_USE_RESET = 11'd1024;

endpackage

`default_nettype wire

FILE: sv/cpfa_req_if.sv
// request channel of the page-frame allocator
// depends on cpfa_pkg for field widths
`default_nettype none

interface cpfa_req_if
    import cpfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  free_address;

    modport source (output valid, output opcode, output page_count, output free_address,
                    input ready);
    modport sink   (input valid, input opcode, input page_count, input free_address,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/cpfa_rsp_if.sv
// response channel of the page-frame allocator
// depends on cpfa_pkg for field widths
`default_nettype none

interface cpfa_rsp_if
    import cpfa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] frame_address;
    logic              success;

    modport source (output valid, output frame_address, output success, input ready);
    modport sink   (input valid, input frame_address, input success, output ready);
endinterface

`default_nettype wire

FILE: sv/cpfa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no package dependency
`default_nettype none

module cpfa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/cpfa_div.sv
// divider by a power-of-two constant: the quotient is a registered right shift
// depends on cpfa_pkg for the address width
`default_nettype none

module cpfa_div
    import cpfa_pkg::*;
#(
    parameter int DIVISOR = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] dividend,
    output      logic              done,
    output      logic [ADDR_W-1:0] quotient
);

    localparam int SHIFT = $clog2(DIVISOR);

    logic              done_reg, done_next;
    logic [ADDR_W-1:0] quot_reg, quot_next;

    // quotient ready the cycle after start
    assign done_next = start;
    assign quot_next = start ? (dividend >> SHIFT) : quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= done_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

FILE: sv/contiguous_page_frame_allocator.sv
// first-fit contiguous page-frame allocator; one item in flight until its result is registered
// allocate: the first free run of N managed frames is marked 1..N; a failed scan, a zero-page
//   or an oversize request fails
// free: clears the addressed frame, then tail frames while their entries stay above one, up to
//   the managed end; out of range fails; one map read a cycle paces scan and walk
// after reset a clearing pass zeroes the map, requests held off meanwhile
`default_nettype none

module contiguous_page_frame_allocator
    import cpfa_pkg::*;
#(
    parameter int FRAMES     = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data,
    cpfa_req_if.sink                  req,
    cpfa_rsp_if.source                rsp
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_MUL, S_DIV, S_WALK, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] in_use_reg;
    logic [COUNT_W-1:0] want_reg, want_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      chk_reg, chk_next;
    logic               pend_reg, pend_next;
    logic [CW-1:0]      run_reg, run_next;
    logic [CW-1:0]      start_reg, start_next;
    logic [CW-1:0]      mk_reg, mk_next;
    logic [ADDR_W-1:0]  prod_reg, prod_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic               out_ok_reg, out_ok_next;
    logic               out_valid_reg, out_valid_next;

    logic [CW-1:0]      limit;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    logic               div_start;
    logic               div_done;
    logic [ADDR_W-1:0]  div_quot;
    logic [CW-1:0]      mark_addr;
    logic [CW-1:0]      mk_inc;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            in_use_reg <= FRAMES_IN_USE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FIRST_FRAME_BASE: base_reg   <= cfg_data;
                REG_FRAMES_IN_USE:    in_use_reg <= cfg_data[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // managed frame count, saturated at the map depth
    always_comb
    begin
        if (MW'(in_use_reg) > MW'(FRAMES))
        begin
            limit = CW'(FRAMES);
        end
        else
        begin
            limit = CW'(in_use_reg);
        end
    end

    assign mark_addr = start_reg + mk_reg;
    assign mk_inc    = mk_reg + 1'b1;

    cpfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAMES)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cpfa_div #(
        .DIVISOR (PAGE_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.free_address - base_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        logic          found;
        logic [CW-1:0] nxt;

        found          = 1'b0;
        nxt            = '0;
        state_next     = state_reg;
        want_next      = want_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        pend_next      = pend_reg;
        run_next       = run_reg;
        start_next     = start_reg;
        mk_next        = mk_reg;
        prod_next      = ADDR_W'(start_reg) * ADDR_W'(PAGE_BYTES);
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        out_addr_next  = out_addr_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IW-1:0];
        mem_wdata      = '0;
        mem_raddr      = idx_reg[IW-1:0];
        div_start      = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(FRAMES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.opcode == OP_FREE)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else if (req.page_count == '0 || MW'(req.page_count) > MW'(limit))
                    begin
                        res_addr_next = '0;
                        res_ok_next   = 1'b0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        want_next  = req.page_count;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        run_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // read one frame ahead, judge the frame read last cycle
                idx_next  = idx_reg + 1'b1;
                chk_next  = idx_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    if (mem_rdata == '0)
                    begin
                        run_next = run_reg + 1'b1;
                        if (run_reg == '0)
                        begin
                            start_next = chk_reg;
                        end
                        found = (MW'(run_reg) + MW'(1) == MW'(want_reg));
                    end
                    else
                    begin
                        run_next = '0;
                    end
                    if (found)
                    begin
                        mk_next    = '0;
                        state_next = S_MARK;
                    end
                    else if (chk_reg == limit - 1'b1)
                    begin
                        res_addr_next = '0;
                        res_ok_next   = 1'b0;
                        state_next    = S_DONE;
                    end
                end
            end
            S_MARK:
            begin
                mem_we    = 1'b1;
                mem_waddr = mark_addr[IW-1:0];
                mem_wdata = ENTRY_W'(mk_inc);
                mk_next   = mk_inc;
                if (MW'(mk_inc) == MW'(want_reg))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                res_addr_next = base_reg + prod_reg;
                res_ok_next   = 1'b1;
                state_next    = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_quot >= ADDR_W'(limit))
                    begin
                        res_addr_next = '0;
                        res_ok_next   = 1'b0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        mem_we        = 1'b1;
                        mem_waddr     = div_quot[IW-1:0];
                        nxt           = div_quot[CW-1:0] + 1'b1;
                        mem_raddr     = nxt[IW-1:0];
                        idx_next      = nxt;
                        res_addr_next = '0;
                        res_ok_next   = 1'b1;
                        state_next    = (nxt < limit) ? S_WALK : S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                // clear the tail of the run while entries stay above one
                nxt = idx_reg + 1'b1;
                if (mem_rdata > ENTRY_W'(1))
                begin
                    mem_we    = 1'b1;
                    mem_raddr = nxt[IW-1:0];
                    idx_next  = nxt;
                    if (!(nxt < limit))
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_addr_next  = res_addr_reg;
                    out_ok_next    = res_ok_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            want_reg      <= '0;
            idx_reg       <= '0;
            chk_reg       <= '0;
            pend_reg      <= 1'b0;
            run_reg       <= '0;
            start_reg     <= '0;
            mk_reg        <= '0;
            prod_reg      <= '0;
            res_addr_reg  <= '0;
            res_ok_reg    <= 1'b0;
            out_addr_reg  <= '0;
            out_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            want_reg      <= want_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            pend_reg      <= pend_next;
            run_reg       <= run_next;
            start_reg     <= start_next;
            mk_reg        <= mk_next;
            prod_reg      <= prod_next;
            res_addr_reg  <= res_addr_next;
            res_ok_reg    <= res_ok_next;
            out_addr_reg  <= out_addr_next;
            out_ok_reg    <= out_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.frame_address = out_addr_reg;
    assign rsp.success       = out_ok_reg;

    a_scan_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !mem_we)
        else $error("frame map written during scan");

    a_clear_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !req.ready)
        else $error("request taken during clearing pass");

    a_transfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("request transfer left block idle");

    a_mark_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MARK |-> mem_we && mem_wdata != '0)
        else $error("run marked with a free entry");

    a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.success |-> rsp.frame_address == '0)
        else $error("failed result carries an address");

endmodule

`default_nettype wire

FILE: test/contiguous_page_frame_allocator_test.sv
// self-checking testbench for the contiguous page-frame allocator
// uses cpfa_pkg and the cpfa_req_if / cpfa_rsp_if channels; holds a frame-map ledger
// that predicts every response, plus tasks that drive requests and register writes
`default_nettype none

module contiguous_page_frame_allocator_test;
    import cpfa_pkg::*;

    localparam int FRAMES       = 1024;
    localparam int PAGE_BYTES   = 4096;
    localparam int LIMIT_CYCLES = 4 * (FRAMES + 600 * (2 * FRAMES + 300));

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic              success;
    } grant_t;

    // mirror of the frame map, register file and the queue of awaited responses
    class page_ledger;
        logic [ADDR_W-1:0]  first_base;
        logic [COUNT_W-1:0] frames_limit;
        logic [ENTRY_W-1:0] frame_map [FRAMES];
        grant_t             awaited [$];
        int                 errors;
        int                 requests;
        int                 checked;

        function new();
            first_base   = '0;
            frames_limit = FRAMES_IN_USE_RESET;
            foreach (frame_map[i]) frame_map[i] = '0;
            errors   = 0;
            requests = 0;
            checked  = 0;
        endfunction

        function void set_config(logic [ADDR_W-1:0] base, logic [COUNT_W-1:0] limit);
            first_base   = base;
            frames_limit = limit;
        endfunction

        function int unsigned managed();
            return (frames_limit > FRAMES) ? FRAMES : frames_limit;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // first fit from frame zero, run marked 1..want
        function grant_t allocate(logic [COUNT_W-1:0] want);
            grant_t      g;
            int unsigned lim;
            int unsigned run_len;
            int unsigned start;
            g       = '0;
            lim     = managed();
            run_len = 0;
            start   = 0;
            if (want == 0 || want > lim)
                return g;
            for (int unsigned i = 0; i < lim; i++)
            begin
                if (frame_map[i] == 0)
                begin
                    if (run_len == 0)
                        start = i;
                    run_len++;
                    if (run_len == want)
                    begin
                        for (int unsigned k = 0; k < want; k++)
                            frame_map[start + k] = ENTRY_W'(k + 1);
                        g.frame_address = first_base + ADDR_W'(start * PAGE_BYTES);
                        g.success       = 1'b1;
                        return g;
                    end
                end
                else
                    run_len = 0;
            end
            return g;
        endfunction

        // clear the addressed frame, then the tail of its run
        function grant_t free_run(logic [ADDR_W-1:0] addr);
            grant_t            g;
            logic [ADDR_W-1:0] rel;
            int unsigned       idx;
            int unsigned       lim;
            g   = '0;
            lim = managed();
            rel = addr - first_base;
            idx = rel / ADDR_W'(PAGE_BYTES);
            if (idx >= lim)
                return g;
            frame_map[idx] = '0;
            idx++;
            while (idx < lim && frame_map[idx] > 1)
            begin
                frame_map[idx] = '0;
                idx++;
            end
            g.success = 1'b1;
            return g;
        endfunction

        function void note_request(logic op, logic [COUNT_W-1:0] count,
                                   logic [ADDR_W-1:0] addr);
            grant_t g;
            requests++;
            if (op == OP_ALLOC)
                g = allocate(count);
            else
                g = free_run(addr);
            awaited.push_back(g);
        endfunction

        function void check_response(logic [ADDR_W-1:0] addr, logic ok);
            grant_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: response with none outstanding: frame_address %h success %b",
                         $time, addr, ok);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (addr !== want.frame_address)
            begin
                errors++;
                $display("%0t: frame_address expected %h actual %h",
                         $time, want.frame_address, addr);
            end
            if (ok !== want.success)
            begin
                errors++;
                $display("%0t: success expected %b actual %b", $time, want.success, ok);
            end
        endfunction

        // a live run start inside the managed frames, or -1 if none
        function int pick_run_start();
            int          starts [$];
            int unsigned lim;
            lim = managed();
            for (int unsigned i = 0; i < lim; i++)
                if (frame_map[i] == 1)
                    starts.push_back(i);
            if (starts.size() == 0)
                return -1;
            return starts[$urandom_range(0, starts.size() - 1)];
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    cpfa_req_if req_ch ();
    cpfa_rsp_if rsp_ch ();

    page_ledger ledger;
    int         send_idle_pct;
    int         stall_pct;
    int         hold_left;
    int         settings_used;
    int         cycles;

    contiguous_page_frame_allocator #(
        .FRAMES     (FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("contiguous_page_frame_allocator_test: errors");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            ledger.check_response(rsp_ch.frame_address, rsp_ch.success);
    end

    task automatic send_item(input logic op, input logic [COUNT_W-1:0] count,
                             input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.page_count   <= count;
        req_ch.free_address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        ledger.note_request(op, count, addr);
    endtask

    // stop offering and let every outstanding transfer complete
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (ledger.outstanding() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [ADDR_W-1:0] base,
                                input logic [COUNT_W-1:0] limit);
        cfg_write <= 1'b1;
        cfg_index <= REG_FIRST_FRAME_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_FRAMES_IN_USE;
        cfg_data  <= ADDR_W'(limit);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        ledger.set_config(base, limit);
        settings_used++;
    endtask

    task automatic random_item();
        int unsigned       kind;
        int unsigned       pick;
        int unsigned       lim;
        int                start;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  addr;
        kind  = $urandom_range(0, 99);
        lim   = ledger.managed();
        count = COUNT_W'($urandom_range(0, 1024));
        addr  = $urandom;
        if (kind < 50)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                count = COUNT_W'($urandom_range(1, 8));
            else if (pick < 85)
                count = COUNT_W'($urandom_range(1, (lim > 0) ? lim : 1));
            else if (pick < 92)
                count = '0;
            else if (pick < 96)
                count = COUNT_W'(1024);
            send_item(OP_ALLOC, count, addr);
        end
        else
        begin
            start = (kind < 85) ? ledger.pick_run_start() : -1;
            if (start < 0 && $urandom_range(0, 3) != 0)
                start = $urandom_range(0, FRAMES + 16);
            if (start >= 0)
                addr = ledger.first_base + ADDR_W'(start * PAGE_BYTES)
                       + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
            send_item(OP_FREE, count, addr);
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] limit,
                             input int idle, input int stall, input int hold, input int items);
        drain();
        write_config(base, limit);
        send_idle_pct = idle;
        stall_pct     = stall;
        hold_left     = hold;
        repeat (items) random_item();
    endtask

    initial
    begin
        ledger              = new();
        send_idle_pct       = 0;
        stall_pct           = 0;
        hold_left           = 0;
        settings_used       = 0;
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = REG_FIRST_FRAME_BASE;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_ALLOC;
        req_ch.page_count   = '0;
        req_ch.free_address = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset values: whole map managed from address zero
        send_item(OP_ALLOC, 11'd0, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 11'd1024, 32'h0);
        send_item(OP_ALLOC, 11'd1, 32'h0);
        send_item(OP_FREE, 11'd1024, 32'h0000_0FFF);
        send_item(OP_FREE, 11'd0, 32'h0040_0000);
        send_item(OP_FREE, 11'd0, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 11'd3, 32'h0);
        send_item(OP_ALLOC, 11'd5, 32'h0);
        // mid-run free, then free of a frame that is already free
        send_item(OP_FREE, 11'd7, 32'h0000_1000);
        send_item(OP_FREE, 11'd0, 32'h001F_4000);
        send_item(OP_ALLOC, 11'd2, 32'h0);

        // shrunk map whose addresses wrap past the top
        drain();
        write_config(32'hFFFF_F000, 11'd4);
        send_item(OP_ALLOC, 11'd1, 32'h0);
        send_item(OP_ALLOC, 11'd4, 32'h0);
        send_item(OP_FREE, 11'd0, 32'h0000_1000);
        send_item(OP_ALLOC, 11'd1, 32'h0);
        send_item(OP_FREE, 11'd0, 32'hFFFF_E000);

        drain();
        write_config(32'h0, 11'd0);
        send_item(OP_ALLOC, 11'd1, 32'h0);
        send_item(OP_FREE, 11'd0, 32'h0);

        // frame count above the map size saturates
        drain();
        write_config(32'h1234_5000, 11'h7FF);
        send_item(OP_ALLOC, 11'd1024, 32'h0);
        send_item(OP_FREE, 11'd0, 32'h1274_4000);
        send_item(OP_ALLOC, 11'd1, 32'h0);

        drain();
        write_config(32'h0, 11'd1);
        send_item(OP_FREE, 11'd0, 32'h0);
        send_item(OP_ALLOC, 11'd1, 32'h0);

        run_phase($urandom, 11'd64, 0, 0, 0, 110);
        run_phase({16'($urandom_range(0, 16'hFFFF)), 16'h0}, 11'd16, 55, 0, 0, 90);
        // long receiver hold-off so the output register fills and requests back up
        run_phase($urandom, 11'd200, 0, 55, 500, 100);
        run_phase(32'h0, 11'd1024, 25, 25, 0, 70);
        run_phase(32'hFFFF_FFFF, 11'h7FF, 0, 0, 0, 60);
        run_phase($urandom, COUNT_W'($urandom_range(1, 100)), 25, 25, 0, 127);

        drain();
        repeat (40) @(posedge clk);
        $display("covered %0d requests (allocations, frees, zero-page, oversize, out of range)",
                 ledger.requests);
        $display("under %0d register settings, %0d responses checked, %0d mismatches",
                 settings_used, ledger.checked, ledger.errors);
        if (ledger.errors == 0 && ledger.outstanding() == 0)
            $display("contiguous_page_frame_allocator_test: clean");
        else
            $display("contiguous_page_frame_allocator_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
